/* rtl/core/assert_macros.svh */
// Assertion macros used by the range expander datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CRE_ASSERT_CLK(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n.
`define CRE_ASSERT(lbl, prop, msg) `CRE_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

/* rtl/core/cre_pkg.sv */
// Types, codes and helper functions of the character range expander.
package cre_pkg;

	localparam int CHAR_W = 8;
	localparam int UPC_W = 4;

	localparam logic [CHAR_W-1:0] DASH_CODE = 8'h2D;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_DIGIT,
		CLS_LOWER,
		CLS_UPPER
	} char_class_t;

	// Jump conditions of a microinstruction; a false condition falls through.
	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_NEVER,
		COND_NO_XFER,
		COND_DASH_HELD,
		COND_HOLD_OK,
		COND_CLASS_MATCH,
		COND_START_EQ_C,
		COND_NEXT_NE_C,
		COND_NOT_LAST,
		COND_NO_DASH
	} cond_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_DASH,
		EMIT_CHAR,
		EMIT_RUN,
		EMIT_TERM
	} emit_t;

	typedef enum logic [1:0] {
		LAST_NEVER,
		LAST_ALWAYS,
		LAST_LINE_OPEN,
		LAST_RUN_END
	} last_sel_t;

	typedef enum logic [2:0] {
		ST_NONE,
		ST_TAKE,
		ST_HOLD,
		ST_LOAD_RUN,
		ST_STEP_RUN,
		ST_CLEAR_LINE
	} state_op_t;

	typedef struct packed {
		cond_t     cond;
		upc_t      target;
		emit_t     emit;
		last_sel_t last_sel;
		state_op_t op;
	} uword_t;

	typedef struct packed {
		logic   load_in;
		logic   advance;
		uword_t w;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic dash_held;
		logic hold_ok;
		logic class_match;
		logic start_eq_c;
		logic next_ne_c;
		logic line_last;
		logic out_busy;
	} status_t;

	typedef struct packed {
		char_t ch;
		logic  line_last;
	} in_item_t;

	typedef struct packed {
		char_t out_char;
		logic  run_last;
		logic  terminator;
	} out_item_t;

	function automatic char_class_t char_class(input char_t c);
		char_class_t cls;
		cls = CLS_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			cls = CLS_DIGIT;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			cls = CLS_LOWER;
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			cls = CLS_UPPER;
		end
		return cls;
	endfunction

endpackage

/* rtl/core/cre_stream_if.sv */
// Valid/ready stream interface used by both channels of the expander.
interface cre_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/cre_useq.sv */
// Microprogram ROM, step counter and jump logic of the range expander.
module cre_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  cre_pkg::status_t status,
	output cre_pkg::ctrl_t   ctrl,
	output logic             in_ready
);
	import cre_pkg::*;

	localparam upc_t UA_WAIT       = 4'd0;
	localparam upc_t UA_DISPATCH   = 4'd1;
	localparam upc_t UA_HOLD_TEST  = 4'd2;
	localparam upc_t UA_PLAIN      = 4'd3;
	localparam upc_t UA_RANGE_TEST = 4'd4;
	localparam upc_t UA_LIT_DASH   = 4'd5;
	localparam upc_t UA_LIT_CHAR   = 4'd6;
	localparam upc_t UA_RUN_LOAD   = 4'd7;
	localparam upc_t UA_RUN_STEP   = 4'd8;
	localparam upc_t UA_RUN_DONE   = 4'd9;
	localparam upc_t UA_HOLD       = 4'd10;
	localparam upc_t UA_LINE_END   = 4'd11;
	localparam upc_t UA_TAIL_TEST  = 4'd12;
	localparam upc_t UA_TAIL_DASH  = 4'd13;
	localparam upc_t UA_TERM       = 4'd14;

	// The microprogram. Each word names a jump condition and target, what to
	// emit, how run_last is formed and which state update happens.
	function automatic uword_t urom(input upc_t a);
		uword_t w;
		unique case (a)
			UA_WAIT:       w = '{COND_NO_XFER, UA_WAIT, EMIT_NONE, LAST_NEVER, ST_NONE};
			UA_DISPATCH:   w = '{COND_DASH_HELD, UA_RANGE_TEST, EMIT_NONE, LAST_NEVER,
				ST_NONE};
			UA_HOLD_TEST:  w = '{COND_HOLD_OK, UA_HOLD, EMIT_NONE, LAST_NEVER, ST_NONE};
			UA_PLAIN:      w = '{COND_ALWAYS, UA_LINE_END, EMIT_CHAR, LAST_LINE_OPEN,
				ST_TAKE};
			UA_RANGE_TEST: w = '{COND_CLASS_MATCH, UA_RUN_LOAD, EMIT_NONE, LAST_NEVER,
				ST_NONE};
			UA_LIT_DASH:   w = '{COND_NEVER, UA_WAIT, EMIT_DASH, LAST_NEVER, ST_NONE};
			UA_LIT_CHAR:   w = '{COND_ALWAYS, UA_LINE_END, EMIT_CHAR, LAST_LINE_OPEN,
				ST_TAKE};
			UA_RUN_LOAD:   w = '{COND_START_EQ_C, UA_RUN_DONE, EMIT_NONE, LAST_NEVER,
				ST_LOAD_RUN};
			UA_RUN_STEP:   w = '{COND_NEXT_NE_C, UA_RUN_STEP, EMIT_RUN, LAST_RUN_END,
				ST_STEP_RUN};
			UA_RUN_DONE:   w = '{COND_ALWAYS, UA_LINE_END, EMIT_NONE, LAST_NEVER, ST_TAKE};
			UA_HOLD:       w = '{COND_NEVER, UA_WAIT, EMIT_NONE, LAST_NEVER, ST_HOLD};
			UA_LINE_END:   w = '{COND_NOT_LAST, UA_WAIT, EMIT_NONE, LAST_NEVER, ST_NONE};
			UA_TAIL_TEST:  w = '{COND_NO_DASH, UA_TERM, EMIT_NONE, LAST_NEVER, ST_NONE};
			UA_TAIL_DASH:  w = '{COND_NEVER, UA_WAIT, EMIT_DASH, LAST_NEVER, ST_NONE};
			UA_TERM:       w = '{COND_ALWAYS, UA_WAIT, EMIT_TERM, LAST_ALWAYS,
				ST_CLEAR_LINE};
			default:       w = '{COND_ALWAYS, UA_WAIT, EMIT_NONE, LAST_NEVER, ST_NONE};
		endcase
		return w;
	endfunction

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t word;
	logic   cond_true;
	logic   advance;

	assign word     = urom(upc_q);
	assign in_ready = (upc_q == UA_WAIT);
	// An emitting step waits while the output register holds a result that is not being taken.
	assign advance  = !((word.emit != EMIT_NONE) && status.out_busy);

	always_comb begin
		unique case (word.cond)
			COND_ALWAYS:      cond_true = 1'b1;
			COND_NEVER:       cond_true = 1'b0;
			COND_NO_XFER:     cond_true = !status.in_valid;
			COND_DASH_HELD:   cond_true = status.dash_held;
			COND_HOLD_OK:     cond_true = status.hold_ok;
			COND_CLASS_MATCH: cond_true = status.class_match;
			COND_START_EQ_C:  cond_true = status.start_eq_c;
			COND_NEXT_NE_C:   cond_true = status.next_ne_c;
			COND_NOT_LAST:    cond_true = !status.line_last;
			COND_NO_DASH:     cond_true = !status.dash_held;
			default:          cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (!advance) begin
			upc_next = upc_q;
		end else if (cond_true) begin
			upc_next = word.target;
		end else begin
			upc_next = upc_q + upc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_WAIT;
		end else begin
			upc_q <= upc_next;
		end
	end

	assign ctrl.load_in = in_ready && status.in_valid;
	assign ctrl.advance = advance;
	assign ctrl.w       = word;

endmodule

/* rtl/core/cre_datapath.sv */
// Line state, run counter and output register of the range expander.
`include "assert_macros.svh"

module cre_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  cre_pkg::ctrl_t     ctrl,
	input  cre_pkg::in_item_t  in_item,
	input  logic               in_valid,
	input  logic               out_ready,
	output cre_pkg::status_t   status,
	output cre_pkg::out_item_t out_item,
	output logic               out_valid
);
	import cre_pkg::*;

	char_t       c_q;
	logic        line_last_q;
	char_t       prev_char_q;
	logic        prev_alnum_q;
	logic        dash_held_q;
	char_t       run_q;
	out_item_t   out_q;
	logic        out_valid_q;

	char_t       run_next;
	char_class_t c_cls;
	char_class_t prev_cls;
	out_item_t   item;
	logic        emit_en;

	assign c_cls    = char_class(c_q);
	assign prev_cls = char_class(prev_char_q);
	// During a range prev_char_q still holds the start, which sets the direction.
	assign run_next = (c_q > prev_char_q) ? run_q + char_t'(1) : run_q - char_t'(1);
	assign emit_en  = ctrl.advance && (ctrl.w.emit != EMIT_NONE);

	always_comb begin
		item = '{out_char: '0, run_last: 1'b0, terminator: 1'b0};
		case (ctrl.w.emit)
			EMIT_DASH: item.out_char = DASH_CODE;
			EMIT_CHAR: item.out_char = c_q;
			EMIT_RUN:  item.out_char = run_next;
			EMIT_TERM: item.terminator = 1'b1;
			default:   item.out_char = '0;
		endcase
		case (ctrl.w.last_sel)
			LAST_ALWAYS:    item.run_last = 1'b1;
			LAST_LINE_OPEN: item.run_last = !line_last_q;
			LAST_RUN_END:   item.run_last = (run_next == c_q) && !line_last_q;
			default:        item.run_last = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			c_q         <= in_item.ch;
			line_last_q <= in_item.line_last;
		end
		if (ctrl.advance && ctrl.w.op == ST_LOAD_RUN) begin
			run_q <= prev_char_q;
		end else if (ctrl.advance && ctrl.w.op == ST_STEP_RUN) begin
			run_q <= run_next;
		end
		if (emit_en) begin
			out_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_char_q  <= '0;
			prev_alnum_q <= 1'b0;
			dash_held_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctrl.advance) begin
				case (ctrl.w.op)
					ST_TAKE: begin
						prev_char_q  <= c_q;
						prev_alnum_q <= (c_cls != CLS_NONE);
						dash_held_q  <= 1'b0;
					end
					ST_HOLD: begin
						dash_held_q <= 1'b1;
					end
					ST_CLEAR_LINE: begin
						prev_char_q  <= '0;
						prev_alnum_q <= 1'b0;
						dash_held_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.in_valid    = in_valid;
	assign status.dash_held   = dash_held_q;
	assign status.hold_ok     = (c_q == DASH_CODE) && prev_alnum_q;
	assign status.class_match = (c_cls != CLS_NONE) && (c_cls == prev_cls);
	assign status.start_eq_c  = (prev_char_q == c_q);
	assign status.next_ne_c   = (run_next != c_q);
	assign status.line_last   = line_last_q;
	assign status.out_busy    = out_valid_q && !out_ready;

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

	`CRE_ASSERT(a_term_is_last, out_valid_q && out_q.terminator |-> out_q.run_last, "term not last")
	`CRE_ASSERT(a_dash_after_alnum, dash_held_q |-> prev_alnum_q, "dash held without alnum start")
	`CRE_ASSERT(a_out_holds, status.out_busy |=> out_valid_q && $stable(out_q), "result changed")

endmodule

/* rtl/core/character_range_expander.sv */
// Top level of the character range expander: sequencer plus datapath.
//
//   channel   role    payload                               transfer when
//   chars     sink    ch[7:0], line_last                    valid && ready
//   results   source  out_char[7:0], run_last, terminator   valid && ready
//
// A character takes one microinstruction per cycle unless an emitting step
// stalls. A plain character, a held dash, a literal dash-character pair and a
// range each take their own steps, and the line's last character adds a tail
// test, an optional trailing dash and the terminator.
// Reset returns the step counter to the wait step and clears the line state.
// A full output register that is not being taken stalls any emitting step.
module character_range_expander (
	input  logic         clk,
	input  logic         arst_n,
	cre_stream_if.sink   chars,
	cre_stream_if.source results
);
	import cre_pkg::*;

	ctrl_t     ctrl;
	status_t   status;
	in_item_t  in_item;
	out_item_t out_item;
	logic      in_ready;
	logic      out_valid;

	// Input characters are taken only in the wait step of the microprogram; the
	// datapath then latches the character and the end-of-line flag.
	assign in_item.ch        = chars.data.ch;
	assign in_item.line_last = chars.data.line_last;
	assign chars.ready       = in_ready;

	// The microprogram walks through dispatch, literal, hold and range steps.
	// The range step loops on itself, emitting one character per cycle unless the full output register stalls it.
	cre_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.ctrl     (ctrl),
		.in_ready (in_ready)
	);

	// The datapath holds the previous character, the held dash, the run cursor
	// and one output register that decouples result transfers from the steps.
	cre_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_item   (in_item),
		.in_valid  (chars.valid),
		.out_ready (results.ready),
		.status    (status),
		.out_item  (out_item),
		.out_valid (out_valid)
	);

	assign results.valid           = out_valid;
	assign results.data.out_char   = out_item.out_char;
	assign results.data.run_last   = out_item.run_last;
	assign results.data.terminator = out_item.terminator;

endmodule
